// ----- hw/rtl/amd_pkg.sv -----
// Shared types and constants for the accelerometer motion detector.
package amd_pkg;

	// Configuration register indexes
	localparam logic CFG_DELTA_THRESHOLD = 1'b0;
	localparam logic CFG_COOLDOWN_MS     = 1'b1;

	// Configuration reset values
	localparam logic [15:0] THRESHOLD_RESET = 16'd400;
	localparam logic [31:0] COOLDOWN_RESET  = 32'd500;

	// Result kinds
	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_MOTION  = 1'b1;

	// Input actions
	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	localparam int NUM_AXES = 3;

	typedef struct packed {
		logic               action;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [31:0]        timestamp_ms;
	} amd_in_t;

	typedef struct packed {
		logic       event_kind;
		logic [7:0] event_count;
	} amd_out_t;

	// Merge stage to output buffer
	typedef struct packed {
		logic     push;
		amd_out_t data;
	} amd_push_t;

endpackage

// ----- hw/rtl/amd_if.sv -----
// Valid/ready channel interfaces for samples in and events out.
interface amd_in_if;
	import amd_pkg::*;
	logic    valid;
	logic    ready;
	amd_in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface amd_out_if;
	import amd_pkg::*;
	logic     valid;
	logic     ready;
	amd_out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/amd_axis_lane.sv -----
// One axis lane: holds the reference sample and flags a change at or above threshold.
module amd_axis_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic signed [15:0] sample,
	input  logic [15:0]        threshold,
	output logic               moved
);
	logic signed [15:0] prev_q;
	logic signed [16:0] diff;
	logic signed [16:0] mag;

	// absolute change, exact in 16 bits unsigned
	always_comb begin
		diff  = 17'(sample) - 17'(prev_q);
		mag   = diff[16] ? -diff : diff;
		moved = (mag[15:0] >= threshold);
	end

	// reference follows every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (load) begin
			prev_q <= sample;
		end
	end
endmodule

// ----- hw/rtl/amd_merge.sv -----
// Merge stage: combines lane flags with cooldown, keeps count and event time.
module amd_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           action,
	input  logic [31:0]                    timestamp_ms,
	input  logic [amd_pkg::NUM_AXES-1:0]   lane_moved,
	input  logic [31:0]                    cooldown_ms,
	output amd_pkg::amd_push_t             push
);
	import amd_pkg::*;

	logic        awaiting_first_q;
	logic [31:0] last_time_q;
	logic [7:0]  count_q;
	logic [31:0] elapsed;
	logic        motion;

	// event decision for the current item
	always_comb begin
		elapsed = timestamp_ms - last_time_q;
		motion  = accept && (action == ACT_SAMPLE) && !awaiting_first_q
			&& (|lane_moved) && (elapsed > cooldown_ms);
		push.push = accept && ((action == ACT_RESTART) || motion);
		if (action == ACT_RESTART) begin
			push.data.event_kind  = KIND_RESTART;
			push.data.event_count = '0;
		end else begin
			push.data.event_kind  = KIND_MOTION;
			push.data.event_count = count_q + 8'd1;
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_first_q <= 1'b1;
			last_time_q      <= '0;
			count_q          <= '0;
		end else if (accept) begin
			if (action == ACT_RESTART) begin
				count_q <= '0;
			end else begin
				awaiting_first_q <= 1'b0;
				if (motion) begin
					count_q     <= count_q + 8'd1;
					last_time_q <= timestamp_ms;
				end
			end
		end
	end

	// restart always leaves a zero count
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_RESTART |=> count_q == 8'd0)
		else $error("count not cleared by restart");

	// a motion event stamps the event time
	a_motion_stamps: assert property (@(posedge clk) disable iff (!arst_n)
		motion |=> last_time_q == $past(timestamp_ms))
		else $error("event time not updated");

	// the first sample never gives a result
	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && awaiting_first_q && action == ACT_SAMPLE |-> !push.push)
		else $error("result on first sample");

	// count moves only through an accepted item
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without an item");
endmodule

// ----- hw/rtl/amd_out_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
module amd_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  amd_pkg::amd_push_t push,
	output logic               full,
	amd_out_if.source          result
);
	import amd_pkg::*;

	logic     head_vld_q;
	logic     skid_vld_q;
	amd_out_t head_q;
	amd_out_t skid_q;
	logic     pop;

	assign pop          = head_vld_q && result.ready;
	assign full         = skid_vld_q;
	assign result.valid = head_vld_q;
	assign result.data  = head_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!head_vld_q) begin
				head_vld_q <= push.push;
			end else if (pop) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					head_vld_q <= push.push;
				end
			end else if (push.push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!head_vld_q || pop) begin
			head_q <= skid_vld_q ? skid_q : push.data;
		end
		if (head_vld_q && !pop && push.push) begin
			skid_q <= push.data;
		end
	end

	// skid is only used behind a full head
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> head_vld_q)
		else $error("skid valid with empty head");

	// no push into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push.push)
		else $error("push into full buffer");
endmodule

// ----- hw/rtl/accel_motion_detector.sv -----
// Top level of the accelerometer any-motion detector with cooldown.
//
//  channel  | dir | handshake     | payload
//  sample   | in  | valid/ready   | action, accel_x/y/z, timestamp_ms
//  result   | out | valid/ready   | event_kind, event_count
//  cfg      | in  | cfg_we        | cfg_idx selects register, cfg_data
//
// One item per cycle while sample.ready is high; each result is registered.
// Three axis lanes compare in parallel; the merge stage holds the feedback
// state (count, event time) and decides within that same cycle.
// sample.ready drops only while both result buffer entries are full.
// arst_n clears state, buffers and sets registers to 400 and 500.
module accel_motion_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data,
	amd_in_if.sink      sample,
	amd_out_if.source   result
);
	import amd_pkg::*;

	logic [15:0]         threshold_q;
	logic [31:0]         cooldown_q;
	logic                accept;
	logic                load;
	logic                full;
	logic [NUM_AXES-1:0] lane_moved;
	amd_push_t           push;

	assign sample.ready = !full;
	assign accept       = sample.valid && !full;
	assign load         = accept && (sample.data.action == ACT_SAMPLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			cooldown_q  <= COOLDOWN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DELTA_THRESHOLD: threshold_q <= cfg_data[15:0];
				CFG_COOLDOWN_MS:     cooldown_q  <= cfg_data;
				default:             ;
			endcase
		end
	end

	// axis lanes
	amd_axis_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .load(load), .sample(sample.data.accel_x),
		.threshold(threshold_q), .moved(lane_moved[0])
	);
	amd_axis_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .load(load), .sample(sample.data.accel_y),
		.threshold(threshold_q), .moved(lane_moved[1])
	);
	amd_axis_lane u_lane_z (
		.clk(clk), .arst_n(arst_n), .load(load), .sample(sample.data.accel_z),
		.threshold(threshold_q), .moved(lane_moved[2])
	);

	// merge lanes with cooldown and count
	amd_merge u_merge (
		.clk(clk), .arst_n(arst_n), .accept(accept), .action(sample.data.action),
		.timestamp_ms(sample.data.timestamp_ms), .lane_moved(lane_moved),
		.cooldown_ms(cooldown_q), .push(push)
	);

	// result buffer
	amd_out_buf u_out_buf (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .result(result)
	);
endmodule
